@@ design/rc4_stream_cipher_unit_defines.svh @@
// Assertion macros shared by the checker file of the RC4 unit.
`ifndef RC4_STREAM_CIPHER_UNIT_DEFINES_SVH
`define RC4_STREAM_CIPHER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RC4_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rc4 check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is high.
`define RC4_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rc4 check failed: next-cycle rule");

`endif

@@ design/rc4_pkg.sv @@
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TABLE_SIZE = 256;

  localparam logic [BYTE_W-1:0] LAST_IDX = 8'hFF;

  // Item kinds on the input channel.
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KS_READ,
    ST_KS_JUMP,
    ST_KS_SWAP_A,
    ST_KS_SWAP_B,
    ST_DT_READ_I,
    ST_DT_READ_J,
    ST_DT_SWAP_A,
    ST_DT_SWAP_B,
    ST_DT_READ_T,
    ST_DT_OUT
  } rc4_state_t;

  // Request from the sequencer to the permutation memory.
  typedef struct packed {
    logic              clr;
    logic              we;
    logic [BYTE_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] raddr;
  } rc4_perm_req_t;

endpackage

@@ design/rc4_perm_ram.sv @@
`timescale 1ns / 1ps

module rc4_perm_ram (
  input  logic                  clk,
  input  logic                  rst,
  input  rc4_pkg::rc4_perm_req_t req,
  output logic [7:0]            rdata
);
  import rc4_pkg::*;

  logic [BYTE_W-1:0]     mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vld;
  logic [BYTE_W-1:0]     mem_q;
  logic [BYTE_W-1:0]     addr_q;
  logic                  vld_q;

  // An entry not written since reset or the last clear holds its own index.
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      vld <= '0;
    end else if (req.we) begin
      vld[req.waddr] <= 1'b1;
    end
  end

  // Single write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    mem_q  <= mem[req.raddr];
    vld_q  <= vld[req.raddr];
    addr_q <= req.raddr;
  end

  assign rdata = vld_q ? mem_q : addr_q;

endmodule

@@ design/rc4_key_ram.sv @@
`timescale 1ns / 1ps

module rc4_key_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/rc4_stream_cipher_unit.sv @@
`timescale 1ns / 1ps

// Channel  Handshake            Payload
// in       in_valid / in_ready  op, in_byte, key_last
// out      out_valid / out_ready out_byte
//
// A key byte leaves the unit idle; the key byte that carries key_last is followed
// by the key schedule, 256 steps each through ST_KS_READ, ST_KS_JUMP, ST_KS_SWAP_A
// and ST_KS_SWAP_B. A data byte runs through the ST_DT_ states, for three dependent
// reads and two writes to the permutation memory, before the next acceptance.
// Reset is synchronous; the permutation reads as identity right after it, with no
// clearing pass. A stalled result holds the unit in its last state until taken.

module rc4_stream_cipher_unit #(
  parameter int unsigned KEY_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] in_byte,
  input  logic       key_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte
);
  import rc4_pkg::*;

  localparam int unsigned KAW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int unsigned CW  = $clog2(KEY_BYTES + 1);

  rc4_state_t        state;
  rc4_state_t        state_next;
  logic [BYTE_W-1:0] idx_i;
  logic [BYTE_W-1:0] idx_j;
  logic [CW-1:0]     key_count;
  logic [KAW-1:0]    pos;
  logic [BYTE_W-1:0] s_a;
  logic [BYTE_W-1:0] s_b;
  logic [BYTE_W-1:0] data_byte;

  rc4_perm_req_t     perm_req;
  logic [BYTE_W-1:0] perm_rdata;
  logic [BYTE_W-1:0] key_rdata;
  logic              key_we;
  logic              accept;

  logic [BYTE_W-1:0] add_a;
  logic [BYTE_W-1:0] add_b;
  logic [BYTE_W-1:0] add_c;
  logic [BYTE_W-1:0] sum;
  logic [CW-1:0]     pos_inc;
  logic              out_load;

  rc4_perm_ram u_perm (
    .clk   (clk),
    .rst   (rst),
    .req   (perm_req),
    .rdata (perm_rdata)
  );

  rc4_key_ram #(
    .DEPTH (KEY_BYTES),
    .AW    (KAW)
  ) u_key (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_count[KAW-1:0]),
    .wdata (in_byte),
    .raddr (pos),
    .rdata (key_rdata)
  );

  assign accept = in_valid && in_ready;
  assign key_we = accept && (op == OP_KEY) && (key_count < CW'(KEY_BYTES));

  // Shared three-input adder, wrapping at 256.
  assign sum     = add_a + add_b + add_c;
  assign pos_inc = CW'(pos) + CW'(1);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_DATA) begin
            state_next = ST_DT_READ_I;
          end else if (key_last) begin
            state_next = ST_KS_READ;
          end
        end
      end
      ST_KS_READ:   state_next = ST_KS_JUMP;
      ST_KS_JUMP:   state_next = ST_KS_SWAP_A;
      ST_KS_SWAP_A: state_next = ST_KS_SWAP_B;
      ST_KS_SWAP_B: state_next = (idx_i == LAST_IDX) ? ST_IDLE : ST_KS_READ;
      ST_DT_READ_I: state_next = ST_DT_READ_J;
      ST_DT_READ_J: state_next = ST_DT_SWAP_A;
      ST_DT_SWAP_A: state_next = ST_DT_SWAP_B;
      ST_DT_SWAP_B: state_next = ST_DT_READ_T;
      ST_DT_READ_T: state_next = ST_DT_OUT;
      ST_DT_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory requests, adder operands, handshake.
  always_comb begin
    perm_req       = '0;
    perm_req.raddr = idx_i;
    add_a          = idx_j;
    add_b          = perm_rdata;
    add_c          = '0;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        perm_req.clr = accept && (op == OP_KEY) && key_last;
      end
      ST_KS_READ: ;
      ST_KS_JUMP: begin
        add_c          = key_rdata;
        perm_req.raddr = sum;
      end
      ST_KS_SWAP_A, ST_DT_SWAP_A: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = idx_i;
        perm_req.wdata = perm_rdata;
      end
      ST_KS_SWAP_B, ST_DT_SWAP_B: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = idx_j;
        perm_req.wdata = s_a;
      end
      ST_DT_READ_I: ;
      ST_DT_READ_J: begin
        perm_req.raddr = sum;
      end
      ST_DT_READ_T: begin
        add_a          = s_a;
        add_b          = s_b;
        perm_req.raddr = sum;
      end
      ST_DT_OUT: begin
        add_a          = s_a;
        add_b          = s_b;
        perm_req.raddr = sum;
        out_load       = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx_i     <= '0;
      idx_j     <= '0;
      key_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && accept && op == OP_DATA) begin
        idx_i <= idx_i + 8'd1;
      end else if (state == ST_IDLE && accept && key_last) begin
        idx_i <= '0;
        idx_j <= '0;
      end else if (state == ST_KS_JUMP || state == ST_DT_READ_J) begin
        idx_j <= sum;
      end else if (state == ST_KS_SWAP_B) begin
        idx_i <= idx_i + 8'd1;
        if (idx_i == LAST_IDX) begin
          idx_j <= '0;
        end
      end

      if (state == ST_KS_SWAP_B && idx_i == LAST_IDX) begin
        key_count <= '0;
      end else if (key_we) begin
        key_count <= key_count + CW'(1);
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      data_byte <= in_byte;
    end
    if (accept && key_last) begin
      pos <= '0;
    end else if (state == ST_KS_JUMP) begin
      pos <= (pos_inc >= key_count) ? '0 : pos_inc[KAW-1:0];
    end
    if (state == ST_KS_JUMP || state == ST_DT_READ_J) begin
      s_a <= perm_rdata;
    end
    if (state == ST_DT_SWAP_A) begin
      s_b <= perm_rdata;
    end
    if (out_load) begin
      out_byte <= data_byte ^ perm_rdata;
    end
  end

endmodule

@@ design/rc4_checker.sv @@
`timescale 1ns / 1ps
`include "rc4_stream_cipher_unit_defines.svh"

module rc4_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       op,
  input logic       key_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte
);
  import rc4_pkg::*;

  // A result that waits keeps its value.
  `RC4_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte))

  // A key transaction never produces a result.
  `RC4_ASSERT_NXT(a_key_no_out, clk, rst, in_valid && in_ready && op == OP_KEY, !$rose(out_valid))

  // The unit is busy right after taking a data transaction.
  `RC4_ASSERT_NXT(a_data_busy, clk, rst, in_valid && in_ready && op == OP_DATA, !in_ready)

  // The final key byte starts the schedule, which blocks new input.
  `RC4_ASSERT_NXT(a_sched_busy, clk, rst,
                  in_valid && in_ready && op == OP_KEY && key_last, !in_ready)

endmodule

bind rc4_stream_cipher_unit rc4_checker u_rc4_checker (.*);
